// ===== hw/rtl/kmms_pkg.sv =====
`timescale 1ns / 1ps
// kmms_pkg: field widths, reset constants and shared structs of the k-way merge
// min-select block. No dependencies; used by kmms_if, kmms_front, kmms_back and the top.

package kmms_pkg;

  localparam int RUN_W       = 4;
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;
  localparam int NUM_W       = 5;
  localparam int CMD_Q_DEPTH = 2;

  localparam logic [NUM_W-1:0] NUM_RUNS_RST = 5'd2;

  // one accepted item that touches a head, passed from front to back
  typedef struct packed {
    logic [RUN_W-1:0]        run_id;
    logic signed [KEY_W-1:0] rec_key;
    logic [PAY_W-1:0]        rec_payload;
    logic                    exhausted;
    logic                    sel;
  } kmms_cmd_t;

  // selection outcome, back to front
  typedef struct packed {
    logic done;
    logic is_end;
  } kmms_sts_t;

endpackage

// ===== hw/rtl/kmms_if.sv =====
`timescale 1ns / 1ps
// kmms_if: valid/ready channel interfaces for the input items and the merged
// result items. Depends on kmms_pkg for field widths.

interface kmms_in_if;
  import kmms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [RUN_W-1:0]        run_id;
  logic signed [KEY_W-1:0] rec_key;
  logic [PAY_W-1:0]        rec_payload;
  logic                    exhausted;

  modport source (output valid, output run_id, output rec_key, output rec_payload,
                  output exhausted, input ready);
  modport sink (input valid, input run_id, input rec_key, input rec_payload,
                input exhausted, output ready);
endinterface

interface kmms_out_if;
  import kmms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] out_key;
  logic [PAY_W-1:0]        out_payload;
  logic [RUN_W-1:0]        from_run;
  logic                    record_valid;
  logic                    last;

  modport source (output valid, output out_key, output out_payload, output from_run,
                  output record_valid, output last, input ready);
  modport sink (input valid, input out_key, input out_payload, input from_run,
                input record_valid, input last, output ready);
endinterface

// ===== hw/rtl/kmms_ram.sv =====
`timescale 1ns / 1ps
// kmms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module kmms_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/kmms_front.sv =====
`timescale 1ns / 1ps
// kmms_front: accepts input items, drops those of unused or unexpected runs,
// counts the fill and issues head commands. Depends on kmms_pkg, kmms_if.

module kmms_front #(
  parameter int  MAX_RUNS = 16,
  localparam int IDX_W    = $clog2(MAX_RUNS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [kmms_pkg::NUM_W-1:0]   eff_n,
  kmms_in_if.sink                      in_ch,
  output logic                         q_push,
  output kmms_pkg::kmms_cmd_t          q_cmd,
  input  logic                         q_ready,
  input  kmms_pkg::kmms_sts_t          sts,
  input  logic [IDX_W-1:0]             sts_run
);
  import kmms_pkg::*;

  logic             merging_r, merging_nxt;
  logic             busy_r, busy_nxt;
  logic [NUM_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [IDX_W-1:0] wait_run_r, wait_run_nxt;
  logic             accept;
  logic             fill_end;

  assign in_ch.ready = !busy_r && q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign fill_end    = (int'(fill_cnt_r) + 1) >= int'(eff_n);

  always_comb begin
    merging_nxt         = merging_r;
    busy_nxt            = busy_r;
    fill_cnt_nxt        = fill_cnt_r;
    wait_run_nxt        = wait_run_r;
    q_push              = 1'b0;
    q_cmd.run_id        = in_ch.run_id;
    q_cmd.rec_key       = in_ch.rec_key;
    q_cmd.rec_payload   = in_ch.rec_payload;
    q_cmd.exhausted     = in_ch.exhausted;
    q_cmd.sel           = 1'b1;

    if (sts.done) begin
      busy_nxt     = 1'b0;
      merging_nxt  = !sts.is_end;
      wait_run_nxt = sts.is_end ? '0 : sts_run;
    end

    if (accept) begin
      if (!merging_r) begin
        if (int'(in_ch.run_id) < int'(eff_n)) begin
          q_push       = 1'b1;
          q_cmd.sel    = fill_end;
          busy_nxt     = fill_end;
          fill_cnt_nxt = fill_end ? '0 : fill_cnt_r + 1'b1;
        end
      end else if (int'(in_ch.run_id) == int'(wait_run_r)) begin
        q_push   = 1'b1;
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merging_r  <= 1'b0;
      busy_r     <= 1'b0;
      fill_cnt_r <= '0;
      wait_run_r <= '0;
    end else begin
      merging_r  <= merging_nxt;
      busy_r     <= busy_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      wait_run_r <= wait_run_nxt;
    end
  end

endmodule

// ===== hw/rtl/kmms_queue.sv =====
`timescale 1ns / 1ps
// kmms_queue: short first-in first-out command queue between front and back.
// No dependencies.

module kmms_queue #(
  parameter int  WIDTH = 72,
  parameter int  DEPTH = 2,
  localparam int PW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign ready   = int'(count_r) < DEPTH;
  assign valid   = count_r != '0;
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/kmms_back.sv =====
`timescale 1ns / 1ps
// kmms_back: writes head records, scans the heads for the smallest key and
// drives the result register. Depends on kmms_pkg, kmms_if, kmms_ram.

module kmms_back #(
  parameter int  MAX_RUNS = 16,
  localparam int IDX_W    = $clog2(MAX_RUNS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [kmms_pkg::NUM_W-1:0]   eff_n,
  input  logic                         q_valid,
  input  kmms_pkg::kmms_cmd_t          q_cmd,
  output logic                         q_pop,
  output kmms_pkg::kmms_sts_t          sts,
  output logic [IDX_W-1:0]             sts_run,
  kmms_out_if.source                   out_ch
);
  import kmms_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_FIN  = 3'b100
  } back_state_t;

  back_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    found_r, found_nxt;
  logic [IDX_W-1:0]        best_r, best_nxt;
  logic signed [KEY_W-1:0] best_key_r, best_key_nxt;
  logic [PAY_W-1:0]        best_pay_r, best_pay_nxt;
  logic [MAX_RUNS-1:0]     present_r, present_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [PAY_W-1:0]        out_pay_r, out_pay_nxt;
  logic [RUN_W-1:0]        out_run_r, out_run_nxt;
  logic                    out_rec_r, out_rec_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         wr_idx;
  logic                     ram_we;
  logic [KEY_W+PAY_W-1:0]   ram_rdata;
  logic signed [KEY_W-1:0]  rd_key;
  logic                     take;
  logic                     out_free;

  assign last_idx = IDX_W'(int'(eff_n) - 1);
  assign wr_idx   = IDX_W'(q_cmd.run_id);
  assign ram_we   = (state_r == B_IDLE) && q_valid && !q_cmd.exhausted;
  assign rd_key   = $signed(ram_rdata[KEY_W+PAY_W-1:PAY_W]);
  assign take     = rd_vld_r && present_r[rd_idx_r] && (!found_r || rd_key < best_key_r);
  assign out_free = !out_valid_r || out_ch.ready;

  kmms_ram #(
    .WIDTH (KEY_W + PAY_W),
    .DEPTH (MAX_RUNS)
  ) u_head_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata ({q_cmd.rec_key, q_cmd.rec_payload}),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_key_nxt  = best_key_r;
    best_pay_nxt  = best_pay_r;
    present_nxt   = present_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_key_nxt   = out_key_r;
    out_pay_nxt   = out_pay_r;
    out_run_nxt   = out_run_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    sts.done      = 1'b0;
    sts.is_end    = !found_r;
    sts_run       = best_r;

    if (take) begin
      found_nxt    = 1'b1;
      best_nxt     = rd_idx_r;
      best_key_nxt = rd_key;
      best_pay_nxt = ram_rdata[PAY_W-1:0];
    end

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop               = 1'b1;
          present_nxt[wr_idx] = !q_cmd.exhausted;
          if (q_cmd.sel) begin
            state_nxt = B_SCAN;
            cnt_nxt   = '0;
            found_nxt = 1'b0;
          end
        end
      end
      B_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = cnt_r;
        if (cnt_r == last_idx) begin
          state_nxt = B_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_FIN: begin
        if (!rd_vld_r && out_free) begin
          sts.done      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
          if (found_r) begin
            out_key_nxt         = best_key_r;
            out_pay_nxt         = best_pay_r;
            out_run_nxt         = RUN_W'(best_r);
            out_rec_nxt         = 1'b1;
            out_last_nxt        = 1'b0;
            present_nxt[best_r] = 1'b0;
          end else begin
            out_key_nxt  = '0;
            out_pay_nxt  = '0;
            out_run_nxt  = '0;
            out_rec_nxt  = 1'b0;
            out_last_nxt = 1'b1;
            present_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_key      = out_key_r;
  assign out_ch.out_payload  = out_pay_r;
  assign out_ch.from_run     = out_run_r;
  assign out_ch.record_valid = out_rec_r;
  assign out_ch.last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      best_r      <= best_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_key_r <= best_key_nxt;
    best_pay_r <= best_pay_nxt;
    out_key_r  <= out_key_nxt;
    out_pay_r  <= out_pay_nxt;
    out_run_r  <= out_run_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== hw/rtl/kway_merge_min_select_top.sv =====
`timescale 1ns / 1ps
// kway_merge_min_select_top: one pass of a k-way merge of sorted runs.
// Depends on kmms_pkg, kmms_if, kmms_front, kmms_queue, kmms_back, kmms_ram.

// Holds one head record per run. Fill items that do not end the fill pass are
// taken at one per cycle while the command queue has room. An item that ends
// the fill, or the refill of the awaited run, triggers a scan of the head RAM
// through its single read port, one run per cycle over the clamped run count;
// the front then takes no new item until the selection is done. The result
// sits in an output register, so the next item is taken while it waits. Ties
// go to the lower run. Heads need no clearing after reset.

module kway_merge_min_select_top #(
  parameter int MAX_RUNS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  kmms_in_if.sink                    in_ch,
  kmms_out_if.source                 out_ch,
  input  logic                       cfg_wr_en,
  input  logic [kmms_pkg::NUM_W-1:0] cfg_wr_data
);
  import kmms_pkg::*;

  localparam int IDX_W = $clog2(MAX_RUNS);

  logic [NUM_W-1:0] num_runs_r, num_runs_nxt;
  logic [NUM_W-1:0] eff_n;
  logic             q_push, q_ready, q_valid, q_pop;
  kmms_cmd_t        push_cmd, pop_cmd;
  kmms_sts_t        sts;
  logic [IDX_W-1:0] sts_run;

  assign num_runs_nxt = cfg_wr_en ? cfg_wr_data : num_runs_r;

  always_comb begin
    if (num_runs_r == '0) begin
      eff_n = NUM_W'(1);
    end else if (int'(num_runs_r) > MAX_RUNS) begin
      eff_n = NUM_W'(MAX_RUNS);
    end else begin
      eff_n = num_runs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_runs_r <= NUM_RUNS_RST;
    end else begin
      num_runs_r <= num_runs_nxt;
    end
  end

  kmms_front #(
    .MAX_RUNS (MAX_RUNS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .eff_n   (eff_n),
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_cmd   (push_cmd),
    .q_ready (q_ready),
    .sts     (sts),
    .sts_run (sts_run)
  );

  kmms_queue #(
    .WIDTH ($bits(kmms_cmd_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_cmd),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (pop_cmd)
  );

  kmms_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .eff_n   (eff_n),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .sts     (sts),
    .sts_run (sts_run),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  a_done_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !q_valid)
    else $error("selection finished with commands still queued");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !sts.done)
    else $error("selection done on two cycles in a row");

  a_no_push_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !sts.done)
    else $error("item queued while a selection was still pending");
`endif

endmodule
